// ===== hw/rtl/piw_pkg.sv =====
package piw_pkg;

	// Request kinds carried in tuser bit 0
	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Input tuser layout
	localparam int S_USER_W     = 2;
	localparam int USER_KIND    = 0;
	localparam int USER_RESTART = 1;

	// Result field layout in m_tdata
	localparam int WSUM_BITS   = 11;
	localparam int STATUS_BITS = 2;
	localparam int OUT_INSIDE  = 0;
	localparam int OUT_ONV     = 1;
	localparam int OUT_SUM_LO  = 2;
	localparam int OUT_STAT_LO = OUT_SUM_LO + WSUM_BITS;
	localparam int M_DATA_W    = ((OUT_STAT_LO + STATUS_BITS + 7) / 8) * 8;

	// Saturation bounds of the reported winding sum
	localparam int WSUM_MAX = (1 << (WSUM_BITS - 1)) - 1;
	localparam int WSUM_MIN = -(1 << (WSUM_BITS - 1));

	typedef logic [STATUS_BITS-1:0] status_t;
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_SMALL = 2'd1;
	localparam status_t STATUS_OVF   = 2'd2;

	// Quadrant of a vertex around the query point, and the change codes
	typedef logic [1:0] quad_t;
	localparam quad_t DELTA_NONE  = 2'd0;
	localparam quad_t DELTA_PLUS  = 2'd1;
	localparam quad_t DELTA_HALF  = 2'd2;
	localparam quad_t DELTA_MINUS = 2'd3;

endpackage

// ===== hw/rtl/piw_ram.sv =====
module piw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hw/rtl/piw_mul.sv =====
module piw_mul #(
	parameter int W = 25
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   op_a,
	input  logic signed [W-1:0]   op_b,
	output logic signed [2*W-1:0] prod
);

	// Register the signed product
	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

// ===== hw/rtl/point_in_polygon_winding.sv =====
// Append request: no result; the next request may follow at once.
// Query over n stored vertices: each vertex is fetched and tested, each ring edge is stepped,
// an edge with a half-turn change adds a shared-multiplier pass (two products and a compare)
// and the sum is then finished and saturated; a vertex hit ends the walk early, n < 3 answers
// as too small without a walk; no request is taken until the result is out.
// Reset clears vertex count, overflow flag and control; vertex memory is not cleared.
module point_in_polygon_winding #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24,
	localparam int S_DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [S_DATA_W-1:0]           s_tdata,  // coord_x, coord_y
	input  logic [piw_pkg::S_USER_W-1:0]  s_tuser,  // kind, restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [piw_pkg::M_DATA_W-1:0]  m_tdata   // inside_res, on_vertex, turn_sum, status
);

	import piw_pkg::*;

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int DW    = COORD_BITS + 1;
	localparam int SUM_W = (AW + 3 > WSUM_BITS + 1) ? AW + 3 : WSUM_BITS + 1;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(WSUM_MAX);
	localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(WSUM_MIN);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_EVAL, S_STEP, S_MUL1, S_MUL2, S_CMP, S_FINISH, S_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;
	logic [AW-1:0]       idx_q;
	logic                closing_q;
	coord_t              px_q, py_q;
	coord_t              cur_x_q, cur_y_q, prev_x_q, prev_y_q, first_x_q, first_y_q;
	quad_t               cur_qd_q, prev_qd_q, first_qd_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [2*DW-1:0]  p1_q;
	logic                res_inside_q, res_onv_q;
	logic [WSUM_BITS-1:0] res_sum_q;
	status_t             res_status_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	coord_t              in_x, in_y, rd_x, rd_y;
	logic                s_acc, is_query, wr_en;
	logic [CNT_W-1:0]    cnt_eff;
	logic [2*COORD_BITS-1:0] rd_data;
	quad_t               rd_qd, delta;
	logic signed [DW-1:0]   mul_a, mul_b;
	logic signed [2*DW-1:0] mul_p;
	logic                last_vtx, adv, out_free;
	status_t             run_status;

	function automatic quad_t quad_of(coord_t vx, coord_t vy, coord_t qx, coord_t qy);
		if (vx > qx && vy >= qy) begin
			return 2'd0;
		end else if (vx <= qx && vy > qy) begin
			return 2'd1;
		end else if (vx < qx && vy <= qy) begin
			return 2'd2;
		end
		return 2'd3;
	endfunction

	function automatic logic signed [DW-1:0] diff(coord_t a, coord_t b);
		return DW'($signed({a[COORD_BITS-1], a})) - DW'($signed({b[COORD_BITS-1], b}));
	endfunction

	// Decode the request
	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_query = (s_tuser[USER_KIND] == KIND_QUERY);
	assign cnt_eff  = s_tuser[USER_RESTART] ? '0 : cnt_q;
	assign wr_en    = s_acc && !is_query && (cnt_eff < CNT_W'(MAX_VERTICES));

	piw_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_eff[AW-1:0]),
		.wr_data ({in_y, in_x}),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rd_x  = rd_data[COORD_BITS-1:0];
	assign rd_y  = rd_data[2*COORD_BITS-1:COORD_BITS];
	assign rd_qd = quad_of(rd_x, rd_y, px_q, py_q);
	assign delta = cur_qd_q - prev_qd_q;

	// Select the operands of the shared multiplier for the edge prev -> cur
	always_comb begin
		if (state_q == S_MUL1) begin
			mul_a = diff(cur_x_q, prev_x_q);
			mul_b = diff(py_q, prev_y_q);
		end else begin
			mul_a = diff(px_q, prev_x_q);
			mul_b = diff(cur_y_q, prev_y_q);
		end
	end

	piw_mul #(.W(DW)) u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	// An edge is finished after a step with no half turn or after the cross compare
	assign last_vtx   = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
	assign adv        = (state_q == S_CMP) || (state_q == S_STEP && delta != DELTA_HALF);
	assign out_free   = !m_tvalid_q || m_tready;
	assign run_status = ovf_q ? STATUS_OVF : STATUS_OK;

	// Sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			closing_q    <= 1'b0;
			px_q         <= '0;
			py_q         <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			cur_qd_q     <= '0;
			prev_qd_q    <= '0;
			first_qd_q   <= '0;
			sum_q        <= '0;
			p1_q         <= '0;
			res_inside_q <= 1'b0;
			res_onv_q    <= 1'b0;
			res_sum_q    <= '0;
			res_status_q <= STATUS_OK;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// drop the result once taken, unless a new one is loaded now
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc && !is_query) begin
						// store the vertex or mark it dropped
						if (s_tuser[USER_RESTART]) begin
							ovf_q <= 1'b0;
						end
						if (wr_en) begin
							cnt_q <= cnt_eff + CNT_W'(1);
						end else begin
							cnt_q <= cnt_eff;
							ovf_q <= 1'b1;
						end
					end else if (s_acc) begin
						px_q      <= in_x;
						py_q      <= in_y;
						idx_q     <= '0;
						closing_q <= 1'b0;
						sum_q     <= '0;
						if (cnt_q < CNT_W'(3)) begin
							res_inside_q <= 1'b0;
							res_onv_q    <= 1'b0;
							res_sum_q    <= '0;
							res_status_q <= STATUS_SMALL;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (rd_x == px_q && rd_y == py_q) begin
						// point sits on a vertex: answer at once
						res_inside_q <= 1'b1;
						res_onv_q    <= 1'b1;
						res_sum_q    <= '0;
						res_status_q <= run_status;
						state_q      <= S_DONE;
					end else if (idx_q == '0) begin
						first_x_q  <= rd_x;
						first_y_q  <= rd_y;
						first_qd_q <= rd_qd;
						prev_x_q   <= rd_x;
						prev_y_q   <= rd_y;
						prev_qd_q  <= rd_qd;
						idx_q      <= idx_q + AW'(1);
						state_q    <= S_FETCH;
					end else begin
						cur_x_q  <= rd_x;
						cur_y_q  <= rd_y;
						cur_qd_q <= rd_qd;
						state_q  <= S_STEP;
					end
				end
				S_STEP: begin
					case (delta)
						DELTA_PLUS:  sum_q <= sum_q + SUM_W'(1);
						DELTA_MINUS: sum_q <= sum_q - SUM_W'(1);
						DELTA_HALF:  state_q <= S_MUL1;
						default:     ;
					endcase
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p1_q    <= mul_p;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// half turn: sign of the cross product picks the direction
					if (p1_q > mul_p) begin
						sum_q <= sum_q + SUM_W'(2);
					end else begin
						sum_q <= sum_q - SUM_W'(2);
					end
				end
				S_FINISH: begin
					res_inside_q <= (sum_q != '0);
					res_onv_q    <= 1'b0;
					if (sum_q > SUM_HI) begin
						res_sum_q <= SUM_HI[WSUM_BITS-1:0];
					end else if (sum_q < SUM_LO) begin
						res_sum_q <= SUM_LO[WSUM_BITS-1:0];
					end else begin
						res_sum_q <= sum_q[WSUM_BITS-1:0];
					end
					res_status_q <= run_status;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_DATA_W'({res_status_q, res_sum_q, res_onv_q,
							res_inside_q});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// advance the walk to the next edge
			if (adv) begin
				prev_x_q  <= cur_x_q;
				prev_y_q  <= cur_y_q;
				prev_qd_q <= cur_qd_q;
				if (closing_q) begin
					state_q <= S_FINISH;
				end else if (last_vtx) begin
					closing_q <= 1'b1;
					cur_x_q   <= first_x_q;
					cur_y_q   <= first_y_q;
					cur_qd_q  <= first_qd_q;
					state_q   <= S_STEP;
				end else begin
					idx_q   <= idx_q + AW'(1);
					state_q <= S_FETCH;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hw/rtl/piw_checker.sv =====
module piw_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [piw_pkg::S_USER_W-1:0]  s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [piw_pkg::M_DATA_W-1:0]  m_tdata
);

	import piw_pkg::*;

	logic                 r_inside, r_onv;
	logic [WSUM_BITS-1:0] r_sum;
	status_t              r_status;

	assign r_inside = m_tdata[OUT_INSIDE];
	assign r_onv    = m_tdata[OUT_ONV];
	assign r_sum    = m_tdata[OUT_SUM_LO +: WSUM_BITS];
	assign r_status = m_tdata[OUT_STAT_LO +: STATUS_BITS];

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Inside flag agrees with vertex hit and winding sum
	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (r_inside == (r_onv || (r_sum != '0))))
		else $error("inside flag does not match sum");

	// Too-small polygon gives an empty answer
	a_small: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r_status == STATUS_SMALL) |-> !r_inside && !r_onv && (r_sum == '0))
		else $error("small polygon result not empty");

	// A query request starts a walk that blocks new requests
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[USER_KIND] == KIND_QUERY) |=> !s_tready)
		else $error("ready right after a query");

endmodule

bind point_in_polygon_winding piw_checker u_piw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== dv/winding_checker.sv =====
`timescale 1ns / 100ps

module winding_checker #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24,
	localparam int S_DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [S_DATA_W-1:0]           s_tdata,  // coord_x, coord_y
	input  logic [piw_pkg::S_USER_W-1:0]  s_tuser,  // kind, restart
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [piw_pkg::M_DATA_W-1:0]  m_tdata,  // inside_res, on_vertex, turn_sum, status
	output int                            fail_count,
	output int                            outstanding
);

	import piw_pkg::*;

	// Quadrant of a vertex around the query point
	typedef enum logic [1:0] {
		QUAD_NE = 2'd0,
		QUAD_NW = 2'd1,
		QUAD_SW = 2'd2,
		QUAD_SE = 2'd3
	} quadrant_e;

	typedef struct packed {
		logic                        in_poly;
		logic                        onv;
		logic signed [WSUM_BITS-1:0] wsum;
		status_t                     status;
		longint                      px;
		longint                      py;
	} answer_t;

	// Shadow copy of the polygon store
	longint      poly_x [MAX_VERTICES];
	longint      poly_y [MAX_VERTICES];
	int unsigned poly_count;
	bit          poly_dropped;

	answer_t     answers_q [$];
	int          errs;
	int          n_results;

	assign fail_count = errs;

	function automatic quadrant_e quadrant_of(longint vx, longint vy, longint px, longint py);
		if (vx > px && vy >= py)
			return QUAD_NE;
		if (vx <= px && vy > py)
			return QUAD_NW;
		if (vx < px && vy <= py)
			return QUAD_SW;
		return QUAD_SE;
	endfunction

	// Contribution of edge a->b for a given quadrant change
	function automatic longint turn_step(quad_t delta, int unsigned a, int unsigned b,
			longint px, longint py);
		longint lhs;
		longint rhs;
		lhs = (poly_x[b] - poly_x[a]) * (py - poly_y[a]);
		rhs = (px - poly_x[a]) * (poly_y[b] - poly_y[a]);
		case (delta)
			DELTA_PLUS:  return 1;
			DELTA_MINUS: return -1;
			DELTA_HALF:  return (lhs > rhs) ? 2 : -2;
			default:     return 0;
		endcase
	endfunction

	// Walk the closed ring and work out the answer to one query
	function automatic answer_t predict_query(longint px, longint py);
		answer_t     ans;
		longint      sum;
		quadrant_e   first_q;
		quadrant_e   prev_q;
		quadrant_e   cur_q;
		int unsigned i;
		ans        = '0;
		ans.px     = px;
		ans.py     = py;
		ans.status = poly_dropped ? STATUS_OVF : STATUS_OK;
		if (poly_count < 3) begin
			ans.status = STATUS_SMALL;
			return ans;
		end
		sum     = 0;
		first_q = QUAD_NE;
		prev_q  = QUAD_NE;
		for (i = 0; i < poly_count; i++) begin
			// stop on the first vertex that equals the point
			if (poly_x[i] == px && poly_y[i] == py) begin
				ans.in_poly = 1'b1;
				ans.onv     = 1'b1;
				return ans;
			end
			cur_q = quadrant_of(poly_x[i], poly_y[i], px, py);
			if (i == 0)
				first_q = cur_q;
			else
				sum += turn_step(quad_t'(cur_q - prev_q), i - 1, i, px, py);
			prev_q = cur_q;
		end
		sum += turn_step(quad_t'(first_q - prev_q), poly_count - 1, 0, px, py);
		ans.in_poly = (sum != 0);
		if (sum > WSUM_MAX)
			ans.wsum = WSUM_BITS'(WSUM_MAX);
		else if (sum < WSUM_MIN)
			ans.wsum = WSUM_BITS'(WSUM_MIN);
		else
			ans.wsum = WSUM_BITS'(sum);
		return ans;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("[%0t] result %0d: %s expected %0d, got %0d", $time, n_results, what,
			want, got);
		errs++;
	endtask

	// Track requests and results at every handshake
	always @(posedge clk or negedge arst_n) begin : track
		answer_t want;
		longint  cx;
		longint  cy;
		if (!arst_n) begin
			poly_count   = 0;
			poly_dropped = 0;
			answers_q.delete();
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				cx = longint'($signed(s_tdata[COORD_BITS-1:0]));
				cy = longint'($signed(s_tdata[COORD_BITS +: COORD_BITS]));
				if (s_tuser[USER_KIND] == KIND_APPEND) begin
					if (s_tuser[USER_RESTART]) begin
						poly_count   = 0;
						poly_dropped = 0;
					end
					if (poly_count < MAX_VERTICES) begin
						poly_x[poly_count] = cx;
						poly_y[poly_count] = cy;
						poly_count++;
					end else begin
						poly_dropped = 1;
					end
				end else begin
					answers_q.push_back(predict_query(cx, cy));
				end
			end
			if (m_tvalid && m_tready) begin
				if (answers_q.size() == 0) begin
					report_mismatch("result with no query pending, data", 0,
						longint'(m_tdata));
				end else begin
					want = answers_q.pop_front();
					if (m_tdata[OUT_INSIDE] !== want.in_poly)
						report_mismatch($sformatf("inside_res (%0d,%0d)", want.px, want.py),
							longint'(want.in_poly), longint'(m_tdata[OUT_INSIDE]));
					if (m_tdata[OUT_ONV] !== want.onv)
						report_mismatch($sformatf("on_vertex (%0d,%0d)", want.px, want.py),
							longint'(want.onv), longint'(m_tdata[OUT_ONV]));
					if (m_tdata[OUT_SUM_LO +: WSUM_BITS] !== want.wsum)
						report_mismatch($sformatf("turn_sum (%0d,%0d)", want.px, want.py),
							longint'(want.wsum),
							longint'($signed(m_tdata[OUT_SUM_LO +: WSUM_BITS])));
					if (m_tdata[OUT_STAT_LO +: STATUS_BITS] !== want.status)
						report_mismatch($sformatf("status (%0d,%0d)", want.px, want.py),
							longint'(want.status),
							longint'(m_tdata[OUT_STAT_LO +: STATUS_BITS]));
				end
				n_results++;
			end
			outstanding <= answers_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	import piw_pkg::*;

	localparam int     MAX_V       = 256;
	localparam int     CB          = 24;
	localparam int     S_DATA_W    = ((2 * CB + 7) / 8) * 8;
	localparam int     ITEM_TARGET = 1350;
	localparam int     TAIL_CYCLES = 2000;
	localparam longint LIMIT_NS    = 150_000_000;
	localparam longint COORD_MAX   = (longint'(1) << (CB - 1)) - 1;
	localparam longint COORD_MIN   = -(longint'(1) << (CB - 1));

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata  = '0;  // coord_x, coord_y
	logic [S_USER_W-1:0]  s_tuser  = '0;  // kind, restart
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;        // inside_res, on_vertex, turn_sum, status

	int                   fail_count;
	int                   outstanding;
	bit                   quiet = 1'b0;
	bit                   calm;
	int unsigned          ready_hold = 0;
	int unsigned          items_sent = 0;

	// Vertices sent for the current polygon, used to aim queries
	longint               ring_x [$];
	longint               ring_y [$];

	point_in_polygon_winding #(
		.MAX_VERTICES (MAX_V),
		.COORD_BITS   (CB)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	winding_checker #(
		.MAX_VERTICES (MAX_V),
		.COORD_BITS   (CB)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side: mostly short, a few long
	always @(posedge clk) begin : ready_gen
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (pick < 60) begin
			m_tready   <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end else if (pick < 92) begin
			m_tready   <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			m_tready   <= 1'b0;
			ready_hold <= $urandom_range(10, 40);
		end
	end

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic longint rand_coord();
		logic signed [CB-1:0] v;
		v = $urandom;
		return longint'(v);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until taken
	task automatic send_req(logic kind, logic rst_flag, longint x, longint y);
		logic [S_USER_W-1:0] user;
		longint              cx;
		longint              cy;
		int unsigned         gap;
		cx                 = clamp_coord(x);
		cy                 = clamp_coord(y);
		user               = '0;
		user[USER_KIND]    = kind;
		user[USER_RESTART] = rst_flag;
		s_tuser  <= user;
		s_tdata  <= {cy[CB-1:0], cx[CB-1:0]};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind == KIND_APPEND) begin
			if (rst_flag) begin
				ring_x.delete();
				ring_y.delete();
			end
			if (ring_x.size() < MAX_V) begin
				ring_x.push_back(cx);
				ring_y.push_back(cy);
			end
		end
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every pending query has been answered
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Star-shaped ring around a center, walked one or more times either way
	task automatic build_star(longint cx, longint cy, longint r, int unsigned n,
			int unsigned turns, bit rev);
		longint      perim;
		longint      t;
		longint      off;
		longint      sx;
		longint      sy;
		longint      scale;
		int unsigned k;
		perim = 8 * r;
		for (k = 0; k < n; k++) begin
			t = (longint'(k) * turns * perim / n) % perim;
			if (rev)
				t = (perim - t) % perim;
			off = t % (2 * r);
			case (t / (2 * r))
				0:       begin sx = r;        sy = -r + off; end
				1:       begin sx = r - off;  sy = r;        end
				2:       begin sx = -r;       sy = r - off;  end
				default: begin sx = -r + off; sy = -r;       end
			endcase
			scale = $urandom_range(50, 100);
			send_req(KIND_APPEND, k == 0, cx + sx * scale / 100, cy + sy * scale / 100);
		end
	endtask

	// Pick a query point aimed at the current polygon
	task automatic aim_query(longint cx, longint cy, longint r, output longint x,
			output longint y);
		int unsigned pick;
		int unsigned i;
		int unsigned j;
		pick = $urandom_range(0, 99);
		i    = (ring_x.size() != 0) ? $urandom_range(0, ring_x.size() - 1) : 0;
		j    = (ring_x.size() != 0) ? (i + 1) % ring_x.size() : 0;
		x    = cx - 2 * r + longint'($urandom_range(0, 4 * r));
		y    = cy - 2 * r + longint'($urandom_range(0, 4 * r));
		if (pick < 15) begin
			x = cx;
			y = cy;
		end else if (pick < 40 || ring_x.size() == 0) begin
			// keep the box point
		end else if (pick < 55) begin
			x = ring_x[i];
			y = ring_y[i];
		end else if (pick < 70) begin
			x = (ring_x[i] + ring_x[j]) / 2;
			y = (ring_y[i] + ring_y[j]) / 2;
		end else if (pick < 80) begin
			x = ring_x[i];
		end else if (pick < 88) begin
			y = ring_y[i];
		end else begin
			x = rand_coord();
			y = rand_coord();
		end
	endtask

	initial begin : stimulus
		longint      cx;
		longint      cy;
		longint      r;
		longint      lim;
		longint      qx;
		longint      qy;
		int unsigned shape;
		int unsigned n;
		int unsigned n_queries;
		int unsigned big_done;
		int unsigned k;
		bit          first_phase;

		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty and two-vertex polygons answer too small
		send_req(KIND_QUERY, 1'b0, 0, 0);
		send_req(KIND_APPEND, 1'b1, COORD_MIN, COORD_MIN);
		send_req(KIND_APPEND, 1'b0, COORD_MAX, COORD_MIN);
		send_req(KIND_QUERY, 1'b0, 5, 5);
		// Full-range square, counterclockwise
		send_req(KIND_APPEND, 1'b0, COORD_MAX, COORD_MAX);
		send_req(KIND_APPEND, 1'b0, COORD_MIN, COORD_MAX);
		send_req(KIND_QUERY, 1'b0, 0, 0);
		send_req(KIND_QUERY, 1'b0, COORD_MIN, COORD_MIN);
		send_req(KIND_QUERY, 1'b0, COORD_MAX, COORD_MAX);
		send_req(KIND_QUERY, 1'b0, COORD_MAX, 0);
		send_req(KIND_QUERY, 1'b0, 0, COORD_MIN);
		send_req(KIND_QUERY, 1'b0, -1, -1);
		// Clockwise triangle: inside, on the slanted edge, outside
		send_req(KIND_APPEND, 1'b1, 0, 0);
		send_req(KIND_APPEND, 1'b0, 0, 100);
		send_req(KIND_APPEND, 1'b0, 100, 0);
		send_req(KIND_QUERY, 1'b0, 10, 10);
		send_req(KIND_QUERY, 1'b0, 50, 50);
		send_req(KIND_QUERY, 1'b0, 100, 100);
		send_req(KIND_QUERY, 1'b0, -5, 50);
		send_req(KIND_QUERY, 1'b1, 30, 30);
		send_req(KIND_QUERY, 1'b0, 0, 50);

		// Random phases: build a polygon, then query it
		cx          = 0;
		cy          = 0;
		r           = 100;
		big_done    = 0;
		first_phase = 1'b1;
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 5) == 0);
			quiet <= calm;
			if (first_phase || $urandom_range(0, 5) == 0)
				drain();

			k = $urandom_range(0, 99);
			if (k < 30)
				r = $urandom_range(1, 8);
			else if (k < 70)
				r = $urandom_range(9, 4000);
			else
				r = $urandom_range(4001, 1 << 22);

			shape     = $urandom_range(0, 99);
			n_queries = $urandom_range(2, 8);
			if (first_phase || (shape < 3 && big_done < 3)) begin
				// at or past capacity: any extra vertices are dropped
				lim = COORD_MAX - r;
				cx  = longint'($urandom_range(0, 2 * lim)) - lim;
				cy  = longint'($urandom_range(0, 2 * lim)) - lim;
				n   = first_phase ? MAX_V + $urandom_range(1, 6)
					: MAX_V + $urandom_range(0, 6);
				build_star(cx, cy, r, n, $urandom_range(1, 3), $urandom_range(0, 1));
				n_queries = 3;
				big_done++;
			end else if (shape < 10) begin
				n = $urandom_range(1, 2);
				for (k = 0; k < n; k++)
					send_req(KIND_APPEND, k == 0, cx + $urandom_range(0, 4) - 2,
						cy + $urandom_range(0, 4) - 2);
				n_queries = $urandom_range(2, 3);
			end else if (shape < 20) begin
				// grow the stored polygon without a restart
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++)
					send_req(KIND_APPEND, 1'b0, cx - r + longint'($urandom_range(0, 2 * r)),
						cy - r + longint'($urandom_range(0, 2 * r)));
			end else if (shape < 45) begin
				lim = COORD_MAX - r;
				cx  = longint'($urandom_range(0, 2 * lim)) - lim;
				cy  = longint'($urandom_range(0, 2 * lim)) - lim;
				n   = $urandom_range(3, 8);
				for (k = 0; k < n; k++)
					send_req(KIND_APPEND, k == 0, cx - r + longint'($urandom_range(0, 2 * r)),
						cy - r + longint'($urandom_range(0, 2 * r)));
			end else begin
				lim = COORD_MAX - r;
				cx  = longint'($urandom_range(0, 2 * lim)) - lim;
				cy  = longint'($urandom_range(0, 2 * lim)) - lim;
				build_star(cx, cy, r, $urandom_range(3, 12),
					($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1,
					$urandom_range(0, 1));
			end

			for (k = 0; k < n_queries; k++) begin
				// occasional noise: any kind, any flag, any coordinates
				if ($urandom_range(0, 99) < 8)
					send_req($urandom_range(0, 1), $urandom_range(0, 1), rand_coord(),
						rand_coord());
				aim_query(cx, cy, r, qx, qy);
				send_req(KIND_QUERY, $urandom_range(0, 1), qx, qy);
			end
			first_phase = 1'b0;
		end

		// Let the last answers arrive, then give the verdict
		calm = 1'b0;
		quiet <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("** point_in_polygon_winding: PASSED **");
		end else begin
			$display("** point_in_polygon_winding: FAILED **");
		end
		$finish;
	end

	// Watchdog on the whole run
	initial begin
		#(LIMIT_NS);
		$display("** point_in_polygon_winding: FAILED **");
		$finish;
	end

endmodule
